// ----- src/bts_pkg.sv -----
// Package of the bilinear texture sampler: item structs, register indexes and constants.
// No dependencies; the sampler core uses it by scoped names.
`timescale 1ns / 1ps

package bts_pkg;

    // Fixed field widths.
    localparam int COORD_W   = 24;
    localparam int INDEX_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int Q88_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 9;

    // Texel store geometry.
    localparam int STORE_DEPTH = 65536;

    // Default configuration of the sampler.
    localparam int DEF_MAX_WIDTH       = 256;
    localparam int DEF_MAX_HEIGHT      = 256;
    localparam int DEF_COORD_FRAC_BITS = 16;

    // Full channel value in Q8.8.
    localparam logic [Q88_W-1:0] FULL_Q88 = 16'hFF00;

    // Item operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_LOADED = 8'd3;

    // Input item.
    typedef struct packed {
        logic                      operation;
        logic [INDEX_W-1:0]        texel_index;
        logic [CHAN_W-1:0]         texel_red;
        logic [CHAN_W-1:0]         texel_green;
        logic [CHAN_W-1:0]         texel_blue;
        logic [CHAN_W-1:0]         texel_alpha;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
    } req_item_t;

    // Result item.
    typedef struct packed {
        logic [Q88_W-1:0] out_red;
        logic [Q88_W-1:0] out_green;
        logic [Q88_W-1:0] out_blue;
        logic [Q88_W-1:0] out_alpha;
    } rsp_item_t;

endpackage

// ----- src/bilinear_texture_sampler_core.sv -----
// Five-stage pipeline; a sample item shows its result in the output register of stage 5.
// Throughput: one item per cycle unless rsp_stall holds the output; two duplicated texel
// memories with two read ports each serve every fetch, so the four neighbors of a sample are read together.
// Reset clears the pipeline valids and the configuration registers (width 1, height 1,
// four channels, no texture); the texel memories are not cleared.
// Uses bts_pkg for item structs, register indexes and constants.
`timescale 1ns / 1ps

module bilinear_texture_sampler_core #(
    parameter int MAX_WIDTH       = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = bts_pkg::DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = bts_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  bts_pkg::req_item_t                req_item,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output bts_pkg::rsp_item_t                rsp_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bts_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam int FB   = COORD_FRAC_BITS;
    localparam int XSW  = $clog2(MAX_WIDTH + 1);
    localparam int YSW  = $clog2(MAX_HEIGHT + 1);
    localparam int PXW  = $clog2(MAX_WIDTH);
    localparam int PYW  = $clog2(MAX_HEIGHT);
    localparam int AW   = $clog2(bts_pkg::STORE_DEPTH);
    localparam int CW   = bts_pkg::COORD_W;
    localparam int HW   = bts_pkg::CHAN_W + FB + 1;
    localparam int RW   = 2 * FB + bts_pkg::CHAN_W;
    localparam logic [FB:0]   ONE = (FB + 1)'(1) << FB;
    localparam logic [RW-1:0] RND = RW'(1) << (2 * FB - 9);

    // Configuration registers.
    logic [bts_pkg::CFG_DAT_W-1:0] tex_width_reg;
    logic [bts_pkg::CFG_DAT_W-1:0] tex_height_reg;
    logic [2:0]                    channel_count_reg;
    logic                          texture_loaded_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg      <= 9'd1;
            tex_height_reg     <= 9'd1;
            channel_count_reg  <= 3'd4;
            texture_loaded_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bts_pkg::CFG_TEX_WIDTH:      tex_width_reg      <= cfg_data;
                bts_pkg::CFG_TEX_HEIGHT:     tex_height_reg     <= cfg_data;
                bts_pkg::CFG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[2:0];
                bts_pkg::CFG_TEXTURE_LOADED: texture_loaded_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective texture size, zero treated as one and saturated to the maximum.
    logic [XSW-1:0] w_size;
    logic [YSW-1:0] h_size;

    always_comb
    begin
        if (tex_width_reg == '0)
            w_size = XSW'(1);
        else if (32'(tex_width_reg) > MAX_WIDTH)
            w_size = XSW'(MAX_WIDTH);
        else
            w_size = XSW'(tex_width_reg);
        if (tex_height_reg == '0)
            h_size = YSW'(1);
        else if (32'(tex_height_reg) > MAX_HEIGHT)
            h_size = YSW'(MAX_HEIGHT);
        else
            h_size = YSW'(tex_height_reg);
    end

    // Pipeline valids and stage enables; a stage loads when empty or when it drains.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5       = !v5_reg || !rsp_stall;
    assign en4       = !v4_reg || en5;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign req_stall = !en1;

    // Stage 1: registered input item.
    bts_pkg::req_item_t s1_item_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_item_reg <= req_item;
    end

    // Coordinate mapping of u: signed fraction times width, floor and ceil clamped.
    logic          neg_u;
    logic [CW-1:0] mag_u;
    logic [FB+XSW-1:0] prod_u;
    logic [FB+XSW:0]   pos_u;
    logic [XSW:0]      ipos_u;
    logic [XSW:0]      d_u;
    logic [XSW:0]      c_u;
    logic [FB-1:0]     fr_u;
    logic [PXW-1:0]    x1_next, x2_next;

    always_comb
    begin
        neg_u  = s1_item_reg.coord_u[CW-1];
        mag_u  = neg_u ? CW'(-s1_item_reg.coord_u) : CW'(s1_item_reg.coord_u);
        prod_u = (FB + XSW)'(mag_u[FB-1:0]) * (FB + XSW)'(w_size);
        if (neg_u)
            pos_u = ((FB + XSW + 1)'(w_size) << FB) - (FB + XSW + 1)'(prod_u);
        else
            pos_u = ((FB + XSW + 1)'(w_size) << FB) + (FB + XSW + 1)'(prod_u);
        ipos_u = pos_u[FB+XSW:FB];
        fr_u   = pos_u[FB-1:0];
        d_u    = ipos_u - (XSW + 1)'(w_size);
        c_u    = d_u + (XSW + 1)'(fr_u != '0);
        if (ipos_u < (XSW + 1)'(w_size))
        begin
            x1_next = '0;
            x2_next = '0;
        end
        else
        begin
            x1_next = PXW'(d_u);
            if (c_u > (XSW + 1)'(w_size) - (XSW + 1)'(1))
                x2_next = PXW'(w_size - XSW'(1));
            else
                x2_next = PXW'(c_u);
        end
    end

    // Coordinate mapping of v: the same against the height.
    logic          neg_v;
    logic [CW-1:0] mag_v;
    logic [FB+YSW-1:0] prod_v;
    logic [FB+YSW:0]   pos_v;
    logic [YSW:0]      ipos_v;
    logic [YSW:0]      d_v;
    logic [YSW:0]      c_v;
    logic [FB-1:0]     fr_v;
    logic [PYW-1:0]    y1_next, y2_next;

    always_comb
    begin
        neg_v  = s1_item_reg.coord_v[CW-1];
        mag_v  = neg_v ? CW'(-s1_item_reg.coord_v) : CW'(s1_item_reg.coord_v);
        prod_v = (FB + YSW)'(mag_v[FB-1:0]) * (FB + YSW)'(h_size);
        if (neg_v)
            pos_v = ((FB + YSW + 1)'(h_size) << FB) - (FB + YSW + 1)'(prod_v);
        else
            pos_v = ((FB + YSW + 1)'(h_size) << FB) + (FB + YSW + 1)'(prod_v);
        ipos_v = pos_v[FB+YSW:FB];
        fr_v   = pos_v[FB-1:0];
        d_v    = ipos_v - (YSW + 1)'(h_size);
        c_v    = d_v + (YSW + 1)'(fr_v != '0);
        if (ipos_v < (YSW + 1)'(h_size))
        begin
            y1_next = '0;
            y2_next = '0;
        end
        else
        begin
            y1_next = PYW'(d_v);
            if (c_v > (YSW + 1)'(h_size) - (YSW + 1)'(1))
                y2_next = PYW'(h_size - YSW'(1));
            else
                y2_next = PYW'(c_v);
        end
    end

    // Stage 2: neighbor positions, weights and the write item.
    logic              s2_op_reg;
    logic [AW-1:0]     s2_index_reg;
    logic [31:0]       s2_texel_reg;
    logic [PXW-1:0]    x1_reg, x2_reg;
    logic [PYW-1:0]    y1_reg, y2_reg;
    logic [FB-1:0]     s2_tx_reg, s2_ty_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_op_reg    <= s1_item_reg.operation;
            s2_index_reg <= AW'(s1_item_reg.texel_index);
            s2_texel_reg <= {s1_item_reg.texel_alpha, s1_item_reg.texel_blue,
                             s1_item_reg.texel_green, s1_item_reg.texel_red};
            x1_reg       <= x1_next;
            x2_reg       <= x2_next;
            y1_reg       <= y1_next;
            y2_reg       <= y2_next;
            s2_tx_reg    <= fr_u;
            s2_ty_reg    <= fr_v;
        end
    end

    // Linear texel addresses, wrapped to the store depth.
    logic [AW-1:0] a00, a01, a10, a11;

    always_comb
    begin
        a00 = AW'(32'(y1_reg) * 32'(w_size) + 32'(x1_reg));
        a01 = AW'(32'(y1_reg) * 32'(w_size) + 32'(x2_reg));
        a10 = AW'(32'(y2_reg) * 32'(w_size) + 32'(x1_reg));
        a11 = AW'(32'(y2_reg) * 32'(w_size) + 32'(x2_reg));
    end

    // Two copies of the texel store, each written by every write item.
    // Items reach the memories in order, so a sample always sees earlier writes.
    logic [31:0] mem_top [bts_pkg::STORE_DEPTH];
    logic [31:0] mem_bot [bts_pkg::STORE_DEPTH];
    logic [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic        mem_we, mem_re;

    assign mem_we = v2_reg && en3 && (s2_op_reg == bts_pkg::OP_WRITE);
    assign mem_re = v2_reg && en3 && (s2_op_reg == bts_pkg::OP_SAMPLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_top[s2_index_reg] <= s2_texel_reg;
        if (mem_re)
        begin
            p00_reg <= mem_top[a00];
            p01_reg <= mem_top[a01];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_bot[s2_index_reg] <= s2_texel_reg;
        if (mem_re)
        begin
            p10_reg <= mem_bot[a10];
            p11_reg <= mem_bot[a11];
        end
    end

    // Stage 3 weights travel beside the memory read data.
    logic [FB-1:0] s3_tx_reg, s3_ty_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_tx_reg <= s2_tx_reg;
            s3_ty_reg <= s2_ty_reg;
        end
    end

    // Horizontal blend per channel; alpha reads as full with fewer than four channels.
    logic [31:0] q00, q01, q10, q11;
    logic [HW-1:0] r0_next [4];
    logic [HW-1:0] r1_next [4];

    always_comb
    begin
        q00 = p00_reg;
        q01 = p01_reg;
        q10 = p10_reg;
        q11 = p11_reg;
        if (channel_count_reg < 3'd4)
        begin
            q00[31:24] = 8'hFF;
            q01[31:24] = 8'hFF;
            q10[31:24] = 8'hFF;
            q11[31:24] = 8'hFF;
        end
        for (int ch = 0; ch < 4; ch++)
        begin
            r0_next[ch] = HW'(q00[ch*8 +: 8]) * HW'(ONE - (FB + 1)'(s3_tx_reg))
                        + HW'(q01[ch*8 +: 8]) * HW'(s3_tx_reg);
            r1_next[ch] = HW'(q10[ch*8 +: 8]) * HW'(ONE - (FB + 1)'(s3_tx_reg))
                        + HW'(q11[ch*8 +: 8]) * HW'(s3_tx_reg);
        end
    end

    // Stage 4: row blends.
    logic [HW-1:0] r0_reg [4];
    logic [HW-1:0] r1_reg [4];
    logic [FB-1:0] s4_ty_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            s4_ty_reg <= s3_ty_reg;
        end
    end

    // Vertical blend and rounding to Q8.8, ties upward; every channel reads as full while no texture is loaded.
    logic [RW-1:0] rv [4];
    logic [bts_pkg::Q88_W-1:0] ch_next [4];

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            rv[ch] = RW'(r0_reg[ch]) * RW'(ONE - (FB + 1)'(s4_ty_reg))
                   + RW'(r1_reg[ch]) * RW'(s4_ty_reg) + RND;
            if (texture_loaded_reg)
                ch_next[ch] = rv[ch][RW-1:2*FB-8];
            else
                ch_next[ch] = bts_pkg::FULL_Q88;
        end
    end

    // Stage 5: output register.
    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            rsp_item.out_red   <= ch_next[0];
            rsp_item.out_green <= ch_next[1];
            rsp_item.out_blue  <= ch_next[2];
            rsp_item.out_alpha <= ch_next[3];
        end
    end

    // Valid bits; write items leave the pipeline at the memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= req_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg && (s2_op_reg == bts_pkg::OP_SAMPLE);
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
        end
    end

    assign rsp_valid = v5_reg;

`ifndef SYNTH
    // A write item never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en3 && s2_op_reg == bts_pkg::OP_WRITE) |=> !v3_reg)
        else $error("write item passed the texel memories");

    // The floor neighbor never lies beyond the ceil neighbor.
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (x1_reg <= x2_reg) && (y1_reg <= y2_reg))
        else $error("neighbor order broken");

    // Blended channels never exceed full.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.out_red <= bts_pkg::FULL_Q88)
                   && (rsp_item.out_green <= bts_pkg::FULL_Q88)
                   && (rsp_item.out_blue <= bts_pkg::FULL_Q88)
                   && (rsp_item.out_alpha <= bts_pkg::FULL_Q88))
        else $error("channel above full");

    // The memories are never read and written by the same item.
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("memory read and write collide");
`endif

endmodule

// ----- sim/tb_bilinear_texture_sampler_core.sv -----
// Self-checking testbench of bilinear_texture_sampler_core: a directed table, then random phases.
// Depends on bts_pkg and the sampler core; results are predicted by a local fixed-point model.
`timescale 1ns / 1ps

module tb_bilinear_texture_sampler_core;

    import bts_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int BLEND_SHIFT = 2 * FRAC_BITS - 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_PHASES = 17;
    localparam int ITEMS_PER_PHASE = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd200;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DAT_W-1:0]  reg_data;
        req_item_t             item;
        bit                    typed;
        rsp_item_t             result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_item_t req_item = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_item_t rsp_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // Local copy of the sampler state.
    logic [31:0] texel_mem [STORE_DEPTH];
    bit          texel_written [STORE_DEPTH];
    logic [8:0]  width_reg = 9'd1;
    logic [8:0]  height_reg = 9'd1;
    logic [2:0]  chan_reg = 3'd4;
    logic        loaded_reg = 1'b0;

    rsp_item_t pending_colors[$];
    stim_row_t rows[$];
    int  error_count = 0;
    bit  quiet = 1'b0;
    bit  valid_up = 1'b0;
    int  hold_cycles = 0;
    int  stall_run = 0;
    int  sent_count = 0;
    bit  pause_done = 1'b0;

    bilinear_texture_sampler_core DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("bilinear_texture_sampler_core verification failed");
        $finish;
    end

    // Maps one coordinate to its two neighbor positions and the blend weight.
    function automatic void map_axis(input logic [23:0] raw, input longint size,
                                     output longint lo, output longint hi, output longint wt);
        longint mag, prod, off, pos, f, c;
        begin
            mag = raw[23] ? (longint'(25'h1000000) - longint'(raw)) : longint'(raw);
            prod = (mag & 64'hFFFF) * size;
            off = size << FRAC_BITS;
            pos = raw[23] ? (off - prod) : (off + prod);
            f = (pos >>> FRAC_BITS) - size;
            wt = pos & 64'hFFFF;
            c = f + ((wt != 0) ? 1 : 0);
            if (f < 0) f = 0;
            if (f > size - 1) f = size - 1;
            if (c < 0) c = 0;
            if (c > size - 1) c = size - 1;
            lo = f;
            hi = c;
        end
    endfunction

    function automatic longint fit_size(input logic [8:0] s);
        begin
            if (s == 0) return 1;
            if (s > 256) return 256;
            return longint'(s);
        end
    endfunction

    // Predicts the filtered color of one sample and reports the four texel addresses.
    function automatic rsp_item_t filter_texels(input req_item_t it, output int addr[4]);
        longint w, h, x1, x2, y1, y2, tx, ty, a, b, c, d, r0, r1, r;
        logic [31:0] px [4];
        logic [15:0] chan [4];
        rsp_item_t res;
        begin
            w = fit_size(width_reg);
            h = fit_size(height_reg);
            map_axis(it.coord_u, w, x1, x2, tx);
            map_axis(it.coord_v, h, y1, y2, ty);
            addr[0] = int'((x1 + y1 * w) & 64'hFFFF);
            addr[1] = int'((x2 + y1 * w) & 64'hFFFF);
            addr[2] = int'((x1 + y2 * w) & 64'hFFFF);
            addr[3] = int'((x2 + y2 * w) & 64'hFFFF);
            for (int k = 0; k < 4; k++)
            begin
                px[k] = texel_mem[addr[k]];
                if (chan_reg < 4) px[k][31:24] = 8'hFF;
            end
            for (int ch = 0; ch < 4; ch++)
            begin
                a = longint'(px[0][ch*8 +: 8]);
                b = longint'(px[1][ch*8 +: 8]);
                c = longint'(px[2][ch*8 +: 8]);
                d = longint'(px[3][ch*8 +: 8]);
                r0 = a * (65536 - tx) + b * tx;
                r1 = c * (65536 - tx) + d * tx;
                r = r0 * (65536 - ty) + r1 * ty;
                r = (r + (64'd1 << (BLEND_SHIFT - 1))) >>> BLEND_SHIFT;
                chan[ch] = loaded_reg ? r[15:0] : FULL_Q88;
            end
            res.out_red = chan[0];
            res.out_green = chan[1];
            res.out_blue = chan[2];
            res.out_alpha = chan[3];
            return res;
        end
    endfunction

    // Applies an accepted item to the local state and queues its color.
    function automatic void absorb_item(input req_item_t it, input bit typed, input rsp_item_t given);
        int addr[4];
        rsp_item_t res;
        begin
            if (it.operation == OP_WRITE)
                texel_mem[it.texel_index] = {it.texel_alpha, it.texel_blue,
                                             it.texel_green, it.texel_red};
            else
            begin
                res = filter_texels(it, addr);
                pending_colors.push_back(typed ? given : res);
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        begin
            if (quiet) return 0;
            r = $urandom_range(0, 99);
            if (r < 60) return 0;
            if (r < 90) return $urandom_range(1, 3);
            if (r < 97) return $urandom_range(4, 10);
            return $urandom_range(20, 50);
        end
    endfunction

    // Offers one item, waits for its acceptance, then idles for a random gap.
    task automatic send_item(input req_item_t it, input bit typed = 1'b0,
                             input rsp_item_t given = '0);
        int gap;
        begin
            if (it.operation == OP_WRITE) texel_written[it.texel_index] = 1'b1;
            req_valid <= 1'b1;
            req_item <= it;
            valid_up = 1'b1;
            do @(posedge clk); while (req_stall);
            absorb_item(it, typed, given);
            sent_count++;
            gap = pick_gap();
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic park_sender();
        begin
            if (valid_up)
            begin
                req_valid <= 1'b0;
                valid_up = 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Waits until every expected color has arrived and the pipeline is empty.
    task automatic drain();
        begin
            park_sender();
            while (pending_colors.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
        begin
            drain();
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= dat;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            case (idx)
                CFG_TEX_WIDTH:      width_reg = dat;
                CFG_TEX_HEIGHT:     height_reg = dat;
                CFG_CHANNEL_COUNT:  chan_reg = dat[2:0];
                CFG_TEXTURE_LOADED: loaded_reg = dat[0];
                default: ;
            endcase
        end
    endtask

    function automatic req_item_t texel_item(input int idx, input logic [31:0] rgba);
        req_item_t it;
        begin
            it = '0;
            it.operation = OP_WRITE;
            it.texel_index = 16'(idx);
            {it.texel_alpha, it.texel_blue, it.texel_green, it.texel_red} = rgba;
            return it;
        end
    endfunction

    function automatic req_item_t sample_item(input logic [23:0] u, input logic [23:0] v);
        req_item_t it;
        begin
            it = '0;
            it.operation = OP_SAMPLE;
            it.coord_u = u;
            it.coord_v = v;
            return it;
        end
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
        stim_row_t row;
        begin
            row = '{ROW_CFG, idx, d, '0, 1'b0, '0};
            rows.push_back(row);
        end
    endfunction

    function automatic void add_item(input req_item_t it, input bit typed = 1'b0,
                                     input logic [63:0] res = '0);
        stim_row_t row;
        begin
            row = '{ROW_ITEM, '0, '0, it, typed, rsp_item_t'(res)};
            rows.push_back(row);
        end
    endfunction

    function automatic logic [23:0] pick_coord();
        begin
            case ($urandom_range(0, 9))
                0: return 24'h000000;
                1: return 24'h800000;
                2: return 24'h7FFFFF;
                3: return {8'($urandom), 16'h0000};
                4: return 24'hFFFFFF;
                default: return 24'($urandom);
            endcase
        end
    endfunction

    function automatic logic [8:0] pick_size();
        begin
            if ($urandom_range(0, 9) < 7) return 9'($urandom_range(1, 8));
            case ($urandom_range(0, 3))
                0: return 9'd0;
                1: return 9'd256;
                2: return 9'd511;
                default: return 9'($urandom_range(0, 511));
            endcase
        end
    endfunction

    // Sends a sample, first writing any neighbor texel that was never written.
    task automatic send_sample(input req_item_t it);
        int addr[4];
        begin
            void'(filter_texels(it, addr));
            for (int k = 0; k < 4; k++)
                if (!texel_written[addr[k]]) send_item(texel_item(addr[k], $urandom));
            send_item(it);
        end
    endtask

    task automatic random_item();
        req_item_t it;
        begin
            it = req_item_t'({$urandom, $urandom, $urandom});
            if ($urandom_range(0, 9) < 7)
                send_sample(sample_item(pick_coord(), pick_coord()));
            else
            begin
                it.operation = OP_WRITE;
                send_item(it);
            end
        end
    endtask

    // Result checking and receiver stalls.
    always @(posedge clk)
    begin
        rsp_item_t want;
        logic [63:0] wb, gb;
        string names [4];
        names = '{"out_red", "out_green", "out_blue", "out_alpha"};
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_colors.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, rsp_item);
                error_count++;
            end
            else
            begin
                want = pending_colors.pop_front();
                wb = want;
                gb = rsp_item;
                for (int k = 0; k < 4; k++)
                    if (wb[63 - 16*k -: 16] !== gb[63 - 16*k -: 16])
                    begin
                        $display("%0t: %s expected %h actual %h", $time, names[k],
                                 wb[63 - 16*k -: 16], gb[63 - 16*k -: 16]);
                        error_count++;
                    end
            end
        end
        if (hold_cycles > 0)
        begin
            rsp_stall <= 1'b1;
            hold_cycles--;
        end
        else if (stall_run > 0)
        begin
            rsp_stall <= 1'b1;
            stall_run--;
        end
        else if (!quiet && $urandom_range(0, 99) < 12)
        begin
            rsp_stall <= 1'b1;
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 2);
        end
        else
            rsp_stall <= 1'b0;
    end

    initial
    begin
        // Directed table: reset defaults first, then a 2x2 texture, three channels and zero sizes.
        add_item(sample_item(24'h000000, 24'h000000), 1'b1, {4{FULL_Q88}});
        add_item(sample_item(24'h7FFFFF, 24'h800000), 1'b1, {4{FULL_Q88}});
        add_item(texel_item(0, 32'h0180_00FF));
        add_cfg(CFG_TEX_WIDTH, 9'd2);
        add_cfg(CFG_TEX_HEIGHT, 9'd2);
        add_cfg(CFG_CHANNEL_COUNT, 9'd4);
        add_cfg(CFG_TEXTURE_LOADED, 9'd1);
        add_cfg(CFG_UNUSED, 9'h1FF);
        add_item(texel_item(1, 32'hFE7F_FF00));
        add_item(texel_item(2, 32'h7856_3412));
        add_item(texel_item(3, 32'hFFFF_FFFF));
        add_item(sample_item(24'h000000, 24'h000000), 1'b1, 64'hFF00_0000_8000_0100);
        add_item(sample_item(24'h800000, 24'h800000), 1'b1, 64'hFF00_0000_8000_0100);
        add_item(sample_item(24'h008000, 24'h008000));
        add_item(sample_item(24'h004000, 24'h00C000));
        add_item(sample_item(24'hFFC000, 24'h7FFFFF));
        add_item(sample_item(24'hFFFFFF, 24'h000001));
        add_cfg(CFG_CHANNEL_COUNT, 9'd3);
        add_item(sample_item(24'h000000, 24'h000000), 1'b1, 64'hFF00_0000_8000_FF00);
        add_item(sample_item(24'h00C000, 24'hFF4000));
        add_cfg(CFG_TEX_WIDTH, 9'd0);
        add_cfg(CFG_TEX_HEIGHT, 9'd0);
        add_cfg(CFG_CHANNEL_COUNT, 9'd4);
        add_item(sample_item(24'h7FFFFF, 24'hFFFFFF), 1'b1, 64'hFF00_0000_8000_0100);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].reg_index, rows[i].reg_data);
            else
                send_item(rows[i].item, rows[i].typed, rows[i].result);
        end

        // Random phases, each under a fresh configuration and a fixed item budget.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            int phase_end;
            write_reg(CFG_TEX_WIDTH, pick_size());
            write_reg(CFG_TEX_HEIGHT, pick_size());
            write_reg(CFG_CHANNEL_COUNT, 9'($urandom_range(0, 7)));
            write_reg(CFG_TEXTURE_LOADED, 9'($urandom_range(0, 9) != 0));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 9'($urandom));
            quiet = ($urandom_range(0, 3) == 0);
            // Back up the output so that the core fills and stalls its input.
            if (p == 3)
            begin
                quiet = 1'b1;
                hold_cycles = 300;
            end
            phase_end = sent_count + ITEMS_PER_PHASE;
            while (sent_count < phase_end)
            begin
                if (p == 8 && !pause_done && phase_end - sent_count <= ITEMS_PER_PHASE / 2)
                begin
                    pause_done = 1'b1;
                    park_sender();
                    while (pending_colors.size() != 0) @(posedge clk);
                end
                random_item();
            end
        end

        drain();
        if (error_count == 0)
            $display("bilinear_texture_sampler_core verification clean");
        else
            $display("bilinear_texture_sampler_core verification failed");
        $finish;
    end

endmodule
